>>> sv/assert_macros.svh
// assertion macros used by xrru_ctrl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define XRRU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen outside reset
`define XRRU_NEVER(lbl, clk, rst, cond, msg) \
   `XRRU_ASSERT(lbl, clk, rst, !(cond), msg)

`endif

>>> sv/xrru_pkg.sv
// shared types, constants and helpers for the xoshiro random range unit
// no dependencies
`timescale 1ns / 1ps

package xrru_pkg;

   localparam int WordWidth = 64;
   localparam int DivSteps  = 64;
   localparam int CntWidth  = $clog2(DivSteps);

   localparam logic [WordWidth-1:0] SMax   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [WordWidth-1:0] SignBit = 64'h8000_0000_0000_0000;

   // generator words after reset, and words 1..3 before seeding steps
   localparam logic [WordWidth-1:0] InitWord0 = 64'd1;
   localparam logic [WordWidth-1:0] InitWord1 = 64'd2;
   localparam logic [WordWidth-1:0] InitWord2 = 64'd3;
   localparam logic [WordWidth-1:0] InitWord3 = 64'd4;

   localparam int RotOut   = 7;
   localparam int ShiftT   = 17;
   localparam int RotState = 45;

   // function codes
   localparam logic [1:0] FuncSeed  = 2'd0;
   localparam logic [1:0] FuncRaw   = 2'd1;
   localparam logic [1:0] FuncMod   = 2'd2;
   localparam logic [1:0] FuncRange = 2'd3;

   typedef struct packed {
      logic       load_req;
      logic       step;
      logic       fin;
      logic [1:0] wr_word;
      logic       div_load;
      logic       div_step;
      logic       rsp_load;
   } xrru_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       err;
   } xrru_status_type;

   function automatic logic [WordWidth-1:0] rotl64(input logic [WordWidth-1:0] x,
                                                   input int k);
      rotl64 = (x << k) | (x >> (WordWidth - k));
   endfunction

endpackage

>>> sv/xrru_datapath.sv
// datapath: generator words, output scrambler, divisor check, serial remainder
// depends on xrru_pkg
`timescale 1ns / 1ps

module xrru_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  xrru_pkg::xrru_cmd_type   cmd,
   output xrru_pkg::xrru_status_type stat,
   input  logic [1:0]               req_func,
   input  logic signed [63:0]       req_seed,
   input  logic signed [63:0]       req_upper,
   input  logic signed [63:0]       req_lower,
   output logic signed [63:0]       rsp_value,
   output logic                     rsp_error
);
   import xrru_pkg::*;

   logic [WordWidth-1:0] w_ff [4];
   logic [WordWidth-1:0] w_in [4];
   logic [1:0]           func_ff;
   logic [WordWidth-1:0] upper_ff, lower_ff;
   logic [WordWidth-1:0] p_ff, out_ff;
   logic [WordWidth:0]   dsub_ff;
   logic [WordWidth-1:0] d_ff;
   logic                 err_ff;
   logic [WordWidth-1:0] q_ff, rem_ff;
   logic                 neg_ff;
   logic [WordWidth-1:0] value_ff;
   logic                 error_ff;

   logic [WordWidth-1:0] t_w, w2x, w3x, rot_p, scr_out, mag, trial, value_in;
   logic [WordWidth:0]   dsub_in;

   always_comb begin
      t_w     = w_ff[1] << ShiftT;
      w2x     = w_ff[2] ^ w_ff[0];
      w3x     = w_ff[3] ^ w_ff[1];
      rot_p   = rotl64(p_ff, RotOut);
      scr_out = (rot_p << 3) + rot_p;
      trial   = {rem_ff[WordWidth-2:0], q_ff[WordWidth-1]};
      if (func_ff == FuncRange) begin
         dsub_in = {upper_ff[WordWidth-1], upper_ff} - {lower_ff[WordWidth-1], lower_ff};
      end else begin
         dsub_in = {upper_ff[WordWidth-1], upper_ff};
      end
      // magnitude of the draw; range mode folds the minimum onto the maximum
      if (func_ff == FuncRange && out_ff == SignBit) begin
         mag = SMax;
      end else if (out_ff[WordWidth-1]) begin
         mag = '0 - out_ff;
      end else begin
         mag = out_ff;
      end
      case (func_ff)
         FuncSeed:  value_in = '0;
         FuncRaw:   value_in = out_ff;
         FuncMod:   value_in = neg_ff ? ('0 - rem_ff) : rem_ff;
         FuncRange: value_in = rem_ff + lower_ff;
         default:   value_in = '0;
      endcase
      if (err_ff && func_ff[1]) begin
         value_in = '0;
      end
   end

   always_comb begin
      w_in = w_ff;
      if (cmd.load_req && req_func == FuncSeed) begin
         w_in[0] = req_seed;
         w_in[1] = InitWord1;
         w_in[2] = InitWord2;
         w_in[3] = InitWord3;
      end else if (cmd.step) begin
         w_in[0] = w_ff[0] ^ w3x;
         w_in[1] = w_ff[1] ^ w2x;
         w_in[2] = w2x ^ t_w;
         w_in[3] = rotl64(w3x, RotState);
      end else if (cmd.fin && cmd.wr_word != 2'd0) begin
         w_in[cmd.wr_word] = scr_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff[0] <= InitWord0;
         w_ff[1] <= InitWord1;
         w_ff[2] <= InitWord2;
         w_ff[3] <= InitWord3;
      end else begin
         w_ff <= w_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff  <= req_func;
         upper_ff <= req_upper;
         lower_ff <= req_lower;
      end
      if (cmd.step) begin
         p_ff    <= (w_ff[1] << 2) + w_ff[1];
         dsub_ff <= dsub_in;
      end
      if (cmd.fin) begin
         out_ff <= scr_out;
         d_ff   <= dsub_ff[WordWidth-1:0] + 64'd1;
         err_ff <= dsub_ff[WordWidth] | (dsub_ff[WordWidth-1:0] >= SMax);
      end
      if (cmd.div_load) begin
         q_ff   <= mag;
         rem_ff <= '0;
         neg_ff <= out_ff[WordWidth-1];
      end else if (cmd.div_step) begin
         q_ff   <= q_ff << 1;
         rem_ff <= (trial >= d_ff) ? (trial - d_ff) : trial;
      end
      if (cmd.rsp_load) begin
         value_ff <= value_in;
         error_ff <= err_ff & func_ff[1];
      end
   end

   assign stat.func = func_ff;
   assign stat.err  = err_ff;
   assign rsp_value = value_ff;
   assign rsp_error = error_ff;

endmodule

>>> sv/xrru_ctrl.sv
// controller: sequences seeding, draw, divisor check, remainder and result transfer
// depends on xrru_pkg and assert_macros.svh
`timescale 1ns / 1ps

module xrru_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  xrru_pkg::xrru_status_type stat,
   output xrru_pkg::xrru_cmd_type    cmd
);
   import xrru_pkg::*;
   `include "assert_macros.svh"

   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StStep = 3'd1;
   localparam logic [2:0] StFin  = 3'd2;
   localparam logic [2:0] StLoad = 3'd3;
   localparam logic [2:0] StDiv  = 3'd4;
   localparam logic [2:0] StOut  = 3'd5;

   localparam logic [CntWidth-1:0] CntLast  = CntWidth'(DivSteps - 1);
   localparam logic [CntWidth-1:0] SeedLast = CntWidth'(2);

   logic [2:0]          state_ff, state_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == StIdle);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cnt_in       = '0;
               state_in     = StStep;
            end
         end
         StStep: begin
            cmd.step = 1'b1;
            state_in = StFin;
         end
         StFin: begin
            cmd.fin = 1'b1;
            if (stat.func == FuncSeed) begin
               cmd.wr_word = cnt_ff[1:0] + 2'd1;
               if (cnt_ff == SeedLast) begin
                  state_in = StOut;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = StStep;
               end
            end else if (stat.func == FuncRaw) begin
               state_in = StOut;
            end else begin
               state_in = StLoad;
            end
         end
         StLoad: begin
            cnt_in = '0;
            if (stat.err) begin
               state_in = StOut;
            end else begin
               cmd.div_load = 1'b1;
               state_in     = StDiv;
            end
         end
         StDiv: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CntLast) begin
               state_in = StOut;
            end
         end
         StOut: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `XRRU_NEVER(a_no_overwrite, clock, reset, cmd.rsp_load && rsp_valid_ff && !rsp_ready, "result overwritten before transfer")
   `XRRU_ASSERT(a_accept_starts, clock, reset, req_valid && req_ready |=> state_ff == StStep, "accepted request did not start a step")
   `XRRU_ASSERT(a_div_ends, clock, reset, state_ff == StDiv && cnt_ff == CntLast |=> state_ff == StOut, "remainder did not finish after last step")
   `XRRU_NEVER(a_seed_wr, clock, reset, cmd.fin && stat.func == FuncSeed && cmd.wr_word == 2'd0, "seeding step with no target word")

endmodule

>>> sv/xoshiro_random_range_unit.sv
// top level of the xoshiro256** random range unit
// depends on xrru_pkg, xrru_ctrl and xrru_datapath
`timescale 1ns / 1ps

// channel  | direction | handshake            | payload
// req      | in        | req_valid/req_ready  | req_func, req_seed, req_upper, req_lower
// rsp      | out       | rsp_valid/rsp_ready  | rsp_value, rsp_error
//
// one request at a time; req_ready is high only while the controller is idle
// seed: load, then three step/scramble pairs; raw draw: load, then one step/scramble pair
// range modes: load, one step/scramble pair, divisor check, then the one-bit-per-cycle
// restoring remainder (64 iterations); a divisor error skips the remainder
// synchronous reset returns the generator words to 1, 2, 3, 4
// a result waiting in the output register holds the next result in the output state until it is taken

module xoshiro_random_range_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic signed [63:0] req_seed,
   input  logic signed [63:0] req_upper,
   input  logic signed [63:0] req_lower,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_value,
   output logic               rsp_error
);
   import xrru_pkg::*;

   // command and status between sequencer and datapath
   xrru_cmd_type    cmd;
   xrru_status_type stat;

   // sequencer: request accept, step count, remainder iterations, result transfer
   xrru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // generator words, scrambler, divisor check and serial remainder
   xrru_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_func  (req_func),
      .req_seed  (req_seed),
      .req_upper (req_upper),
      .req_lower (req_lower),
      .rsp_value (rsp_value),
      .rsp_error (rsp_error)
   );

endmodule
